FILE: hdl/tdes_pkg.sv
// ----------------------------------------------------------------------------
// Triple-DES register engine package
// Shared types, constants and cipher helper functions.
// ----------------------------------------------------------------------------
package tdes_pkg;

    typedef struct packed {
        logic start;
        logic load_rnd;
        logic step_rnd;
        logic next_part;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic rnd_last;
        logic part_last;
    } t_dp_sts;

    localparam logic [31:0] SBOX_NIB [0:63] = '{
        32'h417df40e, 32'h18db2fe2, 32'hbcc66aa3, 32'h87305995,
        32'h288ec1f4, 32'h7b12964d, 32'he739bc5f, 32'hd0650aa3,
        32'h7e48d13f, 32'he4832bf6, 32'had1207c9, 32'h5ab5906c,
        32'h1ba78ed0, 32'h214df43a, 32'hc67c68b5, 32'h9fe25309,
        32'h9e0970da, 32'ha56f4336, 32'he75c8d21, 32'h18f2b4cb,
        32'h09d4a61d, 32'h70839f68, 32'h3ce2f14b, 32'hc72e5ab5,
        32'h53be8dd7, 32'h3a09f660, 32'hc5287241, 32'h9fe4ac1b,
        32'h6009f63a, 32'h8dd71bac, 32'hbe53419f, 32'he42872c5,
        32'hc124bce2, 32'h16db7a47, 32'haff30558, 32'h698e903d,
        32'h7bc182b4, 32'hd827ed1a, 32'h950cf96f, 32'h3e5043a6,
        32'h2f4af1ac, 32'h5896c279, 32'he4d31d60, 32'h8b35b70e,
        32'hc52f3e49, 32'ha3fc5892, 32'h7a14e0b7, 32'hd68b0d61,
        32'h7eb20bd4, 32'had18904f, 32'hc7593ce3, 32'h6186fa25,
        32'h8ddbb461, 32'h7ea7431c, 32'hf8065f9a, 32'hc23925e0,
        32'h84d8f21d, 32'h417b3fa6, 32'hbe6359ca, 32'h279ce005,
        32'h71e41b27, 32'hd28eac49, 32'h0d9ac6f0, 32'hb865533f
    };

    localparam logic [4:0] P_PLACE [0:31] = '{
        5'd24, 5'd16, 5'd10, 5'd2,  5'd20, 5'd5,  5'd31, 5'd15,
        5'd9,  5'd17, 5'd3,  5'd27, 5'd7,  5'd13, 5'd23, 5'd0,
        5'd25, 5'd19, 5'd8,  5'd30, 5'd29, 5'd4,  5'd22, 5'd14,
        5'd1,  5'd21, 5'd11, 5'd26, 5'd28, 5'd6,  5'd18, 5'd12
    };

    localparam logic [5:0] CHOICE1 [0:55] = '{
        6'd24, 6'd17, 6'd10, 6'd3,  6'd53, 6'd46, 6'd39, 6'd32, 6'd25, 6'd18,
        6'd11, 6'd4,  6'd54, 6'd47, 6'd40, 6'd33, 6'd26, 6'd19, 6'd12, 6'd5,
        6'd55, 6'd48, 6'd41, 6'd34, 6'd27, 6'd20, 6'd13, 6'd6,  6'd52, 6'd45,
        6'd38, 6'd31, 6'd51, 6'd44, 6'd37, 6'd30, 6'd23, 6'd16, 6'd9,  6'd2,
        6'd50, 6'd43, 6'd36, 6'd29, 6'd22, 6'd15, 6'd8,  6'd1,  6'd49, 6'd42,
        6'd35, 6'd28, 6'd21, 6'd14, 6'd7,  6'd0
    };

    localparam logic [4:0] CHOICE2 [0:47] = '{
        5'd26, 5'd15, 5'd8,  5'd1,  5'd21, 5'd12, 5'd20, 5'd2,  5'd24, 5'd16,
        5'd9,  5'd5,  5'd18, 5'd7,  5'd22, 5'd13, 5'd0,  5'd25, 5'd23, 5'd27,
        5'd4,  5'd17, 5'd11, 5'd14, 5'd24, 5'd27, 5'd20, 5'd6,  5'd14, 5'd10,
        5'd3,  5'd22, 5'd0,  5'd17, 5'd7,  5'd12, 5'd8,  5'd23, 5'd11, 5'd5,
        5'd16, 5'd26, 5'd1,  5'd9,  5'd19, 5'd25, 5'd4,  5'd15
    };

    localparam logic [15:0] SHIFT_TWO = 16'b0011_1111_0111_1110;

    localparam logic [25:0] OFF_DATA_LO = 26'h0;
    localparam logic [25:0] OFF_DATA_HI = 26'h4;
    localparam logic [25:0] OFF_KEY_LO  = 26'h8;
    localparam logic [25:0] OFF_KEY_HI  = 26'h1C;

    function automatic logic [31:0] sp_box(input logic [2:0] box, input logic [5:0] n);
        logic [31:0] w;
        logic [3:0]  v;
        logic [31:0] r;
        w = SBOX_NIB[{box, n[5:3]}];
        v = w[{n[2:0], 2'b00} +: 4];
        r = '0;
        r[P_PLACE[{box, 2'd0}]] = v[3];
        r[P_PLACE[{box, 2'd1}]] = v[2];
        r[P_PLACE[{box, 2'd2}]] = v[1];
        r[P_PLACE[{box, 2'd3}]] = v[0];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] x, input logic two);
        return two ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
    endfunction

    function automatic logic [27:0] rotr28(input logic [27:0] x, input logic two);
        return two ? {x[1:0], x[27:2]} : {x[0], x[27:1]};
    endfunction

endpackage

FILE: hdl/tdes_ctrl.sv
// ----------------------------------------------------------------------------
// Triple-DES controller
// Sequences the three key parts of sixteen rounds each for one operation.
// ----------------------------------------------------------------------------
module tdes_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tdes_pkg::t_dp_sts i_sts,
    output tdes_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import tdes_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_FINISH} t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:   if (i_start) r_state <= S_LOAD;
                S_LOAD:   r_state <= S_ROUND;
                S_ROUND:  if (i_sts.rnd_last) r_state <= i_sts.part_last ? S_FINISH : S_LOAD;
                S_FINISH: r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.start     = (r_state == S_IDLE) && i_start;
        o_cmd.load_rnd  = (r_state == S_LOAD);
        o_cmd.step_rnd  = (r_state == S_ROUND);
        o_cmd.next_part = (r_state == S_ROUND) && i_sts.rnd_last;
        o_cmd.finish    = (r_state == S_FINISH);
        o_busy          = (r_state != S_IDLE);
        o_done          = (r_state == S_FINISH);
    end
endmodule

FILE: hdl/tdes_datapath.sv
// ----------------------------------------------------------------------------
// Triple-DES datapath
// Holds the data halves, the key schedule registers and one round unit.
// ----------------------------------------------------------------------------
module tdes_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdes_pkg::t_dp_cmd i_cmd,
    input  logic [31:0]       i_left,
    input  logic [31:0]       i_right,
    input  logic [191:0]      i_keys,
    output tdes_pkg::t_dp_sts o_sts,
    output logic [31:0]       o_left,
    output logic [31:0]       o_right
);
    import tdes_pkg::*;

    logic [31:0] r_l, r_r, n_l, n_r;
    logic [27:0] r_c, r_d, n_c, n_d;
    logic [3:0]  r_rnd;
    logic [1:0]  r_part;
    logic        r_dec;
    logic [31:0] ip_l, ip_r, fp_l, fp_r, t;
    logic [27:0] c0, d0, cs, ds;
    logic [23:0] kl, kr;
    logic [31:0] k_odd, k_even, o, e, f;
    logic [1:0]  key_sel;
    logic [63:0] kp;
    logic        rev, two;
    logic [3:0]  sidx;

    // The whole schedule of a part runs forward when encrypting that part and
    // backward (right rotations from the sixteenth pair) when it is reversed.
    assign rev     = r_dec ^ r_part[0];
    assign key_sel = r_dec ? 2'd2 - r_part : r_part;
    assign kp      = i_keys[{key_sel, 6'd0} +: 64];
    assign sidx    = rev ? 4'd15 - r_rnd : r_rnd;
    assign two     = SHIFT_TWO[4'd15 - sidx];

    always_comb begin
        for (int b = 0; b < 28; b++) begin
            c0[b] = kp[CHOICE1[b]];
            d0[b] = kp[CHOICE1[28 + b]];
        end
    end

    always_comb begin
        if (rev) begin
            cs = r_c;
            ds = r_d;
        end else begin
            cs = rot28(r_c, two);
            ds = rot28(r_d, two);
        end
        for (int b = 0; b < 24; b++) begin
            kl[b] = cs[CHOICE2[b]];
            kr[b] = ds[CHOICE2[24 + b]];
        end
        k_odd  = ({2'b0, kl, 6'b0} & 32'h3F000000) | ({kl[21:0], 10'b0} & 32'h003F0000)
               | ({8'b0, kr} >> 10 & 32'h00003F00) | ({6'b0, kr, 2'b0} >> 8 & 32'h0000003F);
        k_even = ({kl[19:0], 12'b0} & 32'h3F000000) | ({kl[15:0], 16'b0} & 32'h003F0000)
               | ({4'b0, kr, 4'b0} >> 8 & 32'h00003F00) | ({8'b0, kr} & 32'h0000003F);
        o = k_odd ^ {r_r[3:0], r_r[31:4]};
        e = k_even ^ r_r;
        f = sp_box(3'd0, o[29:24]) ^ sp_box(3'd1, e[29:24])
          ^ sp_box(3'd2, o[21:16]) ^ sp_box(3'd3, e[21:16])
          ^ sp_box(3'd4, o[13:8])  ^ sp_box(3'd5, e[13:8])
          ^ sp_box(3'd6, o[5:0])   ^ sp_box(3'd7, e[5:0]);
    end

    always_comb begin
        ip_l = i_left;
        ip_r = i_right;
        t = ((ip_l >> 4) ^ ip_r) & 32'h0F0F0F0F;  ip_r ^= t; ip_l ^= t << 4;
        t = ((ip_l >> 16) ^ ip_r) & 32'h0000FFFF; ip_r ^= t; ip_l ^= t << 16;
        t = ((ip_r >> 2) ^ ip_l) & 32'h33333333;  ip_l ^= t; ip_r ^= t << 2;
        t = ((ip_r >> 8) ^ ip_l) & 32'h00FF00FF;  ip_l ^= t; ip_r ^= t << 8;
        ip_r = {ip_r[30:0], ip_r[31]};
        t = (ip_l ^ ip_r) & 32'hAAAAAAAA; ip_r ^= t; ip_l ^= t;
        ip_l = {ip_l[30:0], ip_l[31]};

        fp_l = {r_l[0], r_l[31:1]};
        fp_r = r_r;
        t = (fp_l ^ fp_r) & 32'hAAAAAAAA; fp_r ^= t; fp_l ^= t;
        fp_r = {fp_r[0], fp_r[31:1]};
        t = ((fp_r >> 8) ^ fp_l) & 32'h00FF00FF;  fp_l ^= t; fp_r ^= t << 8;
        t = ((fp_r >> 2) ^ fp_l) & 32'h33333333;  fp_l ^= t; fp_r ^= t << 2;
        t = ((fp_l >> 16) ^ fp_r) & 32'h0000FFFF; fp_r ^= t; fp_l ^= t << 16;
        t = ((fp_l >> 4) ^ fp_r) & 32'h0F0F0F0F;  fp_r ^= t; fp_l ^= t << 4;
    end

    always_comb begin
        n_l = r_l;
        n_r = r_r;
        n_c = r_c;
        n_d = r_d;
        if (i_cmd.start) begin
            n_l = ip_l;
            n_r = ip_r;
        end else if (i_cmd.load_rnd) begin
            // Sixteen pair rotations total 28, so the reversed part starts unrotated.
            n_c = c0;
            n_d = d0;
        end else if (i_cmd.step_rnd) begin
            if (i_cmd.next_part) begin
                n_l = r_l ^ f;
            end else begin
                n_l = r_r;
                n_r = r_l ^ f;
            end
            n_c = rev ? rotr28(r_c, two) : cs;
            n_d = rev ? rotr28(r_d, two) : ds;
        end else if (i_cmd.finish) begin
            n_l = fp_l;
            n_r = fp_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l <= n_l;
        r_r <= n_r;
        r_c <= n_c;
        r_d <= n_d;
        if (!i_rst_n) begin
            r_rnd  <= '0;
            r_part <= '0;
            r_dec  <= 1'b0;
        end else if (i_cmd.start) begin
            r_rnd  <= '0;
            r_part <= '0;
            r_dec  <= i_keys[62];
        end else if (i_cmd.step_rnd) begin
            r_rnd <= r_rnd + 4'd1;
            if (i_cmd.next_part) begin
                r_part <= r_part + 2'd1;
            end
        end
    end

    assign o_sts.rnd_last  = (r_rnd == 4'd15);
    assign o_sts.part_last = (r_part == 2'd2);
    assign o_left  = fp_l;
    assign o_right = fp_r;
endmodule

FILE: hdl/triple_des_register_engine_core.sv
// ----------------------------------------------------------------------------
// Triple-DES register engine
// Bus-mapped three-key EDE DES with data and key registers.
// ----------------------------------------------------------------------------
// A write to the high data word starts an operation: one load of the input,
// then three parts of one schedule load and sixteen rounds each, and then
// the final permutation. The datapath computes one round per cycle.
// One transaction is taken at a time. Synchronous active-low reset clears
// the data and key registers and the controller.
module triple_des_register_engine_core #(
    parameter logic [25:0] REG_BASE = 26'h10000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // offset[25:0], write_data[57:26], zero fill
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // read_data
    output logic        m_axis_tuser   // bad_access
);
    import tdes_pkg::*;

    logic [31:0]  r_lo, r_hi;
    logic [191:0] r_keys;
    logic         r_ovalid, r_obad;
    logic [31:0]  r_odata;
    logic         acc, wr, busy, done;
    logic [25:0]  off, rel;
    logic [31:0]  wd;
    logic [31:0]  dp_l, dp_r;
    logic [2:0]   kidx;
    t_dp_cmd      cmd;
    t_dp_sts      sts;
    logic         go;

    assign s_axis_tready = !r_ovalid && !busy;
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign wr   = s_axis_tuser;
    assign off  = s_axis_tdata[25:0];
    assign wd   = s_axis_tdata[57:26];
    assign rel  = off - REG_BASE;
    assign kidx = 3'(rel[4:2] - 3'd2);
    assign go   = acc && wr && off == REG_BASE + OFF_DATA_HI;

    tdes_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(go),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy),
        .o_done (done)
    );

    tdes_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_left (wd),
        .i_right(r_lo),
        .i_keys (r_keys),
        .o_sts  (sts),
        .o_left (dp_l),
        .o_right(dp_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo     <= '0;
            r_hi     <= '0;
            r_keys   <= '0;
            r_ovalid <= 1'b0;
            r_obad   <= 1'b0;
            r_odata  <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (done) begin
                r_lo     <= dp_r;
                r_hi     <= dp_l;
                r_ovalid <= 1'b1;
            end
            if (acc && !go) begin
                r_ovalid <= 1'b1;
                if (!wr) begin
                    if (off == REG_BASE + OFF_DATA_LO) begin
                        r_odata <= r_lo;
                        r_obad  <= 1'b0;
                    end else if (off == REG_BASE + OFF_DATA_HI) begin
                        r_odata <= r_hi;
                        r_obad  <= 1'b0;
                    end else begin
                        r_odata <= '0;
                        r_obad  <= 1'b1;
                    end
                end else begin
                    r_odata <= '0;
                    if (off == REG_BASE + OFF_DATA_LO) begin
                        r_lo   <= wd;
                        r_obad <= 1'b0;
                    end else if (off >= REG_BASE + OFF_KEY_LO && off <= REG_BASE + OFF_KEY_HI
                                 && off[1:0] == 2'b00) begin
                        r_keys[{kidx, 5'd0} +: 32] <= wd;
                        r_obad <= 1'b0;
                    end else begin
                        r_obad <= 1'b1;
                    end
                end
            end
            if (go) begin
                r_odata <= '0;
                r_obad  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_obad;
endmodule

FILE: tb/tb_triple_des_register_engine_checker.sv
// ----------------------------------------------------------------------------
// Triple-DES register engine checker
// Watches both streams, predicts every response from its own model of the
// register map and the EDE cipher, and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_triple_des_register_engine_checker #(
    parameter logic [25:0] REG_BASE = 26'h10000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [63:0] i_req_data,
    input  logic        i_req_user,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_data,
    input  logic        i_rsp_user,
    output int          o_errors,
    output int          o_pending,
    output int          o_ciphers
);
    import tdes_pkg::*;

    typedef struct packed {
        logic [31:0] rdata;
        logic        bad;
    } t_rsp;

    localparam logic ACT_READ  = 1'b0;

    logic [31:0] m_lo, m_hi;
    logic [31:0] m_key [0:5];
    t_rsp        rsp_q [$];

    function automatic logic [31:0] sp_lookup(input int box, input logic [5:0] n);
        logic [3:0]  v;
        logic [31:0] r;
        v = 4'(SBOX_NIB[box * 8 + n[5:3]] >> (n[2:0] * 4));
        r = '0;
        r[P_PLACE[box * 4]]     = v[3];
        r[P_PLACE[box * 4 + 1]] = v[2];
        r[P_PLACE[box * 4 + 2]] = v[1];
        r[P_PLACE[box * 4 + 3]] = v[0];
        return r;
    endfunction

    task automatic ede_encrypt(input logic [31:0] li, input logic [31:0] ri);
        logic [31:0] odd [0:2][0:15];
        logic [31:0] evn [0:2][0:15];
        logic [27:0] c, d;
        logic [23:0] kl, kr;
        logic [31:0] l, r, t, o, e, f;
        logic        dec;
        int          sl, ps, sh, kb;
        dec = m_key[1][30];
        for (int p = 0; p < 3; p++) begin
            c = '0;
            d = '0;
            for (int b = 0; b < 28; b++) begin
                kb = CHOICE1[b];
                c[b] = m_key[p * 2 + kb / 32][kb % 32];
                kb = CHOICE1[28 + b];
                d[b] = m_key[p * 2 + kb / 32][kb % 32];
            end
            for (int n = 0; n < 16; n++) begin
                sh = (n == 0 || n == 1 || n == 8 || n == 15) ? 1 : 2;
                repeat (sh) begin
                    c = {c[26:0], c[27]};
                    d = {d[26:0], d[27]};
                end
                for (int b = 0; b < 24; b++) begin
                    kl[b] = c[CHOICE2[b]];
                    kr[b] = d[CHOICE2[24 + b]];
                end
                sl = dec ? 2 - p : p;
                ps = ((dec ^ p[0]) != 0) ? 15 - n : n;
                odd[sl][ps] = ({8'd0, kl} << 6 & 32'h3F000000) | ({8'd0, kl} << 10 & 32'h003F0000)
                            | ({8'd0, kr} >> 10 & 32'h00003F00) | ({8'd0, kr} >> 6 & 32'h3F);
                evn[sl][ps] = ({8'd0, kl} << 12 & 32'h3F000000) | ({8'd0, kl} << 16 & 32'h003F0000)
                            | ({8'd0, kr} >> 4 & 32'h00003F00) | ({8'd0, kr} & 32'h3F);
            end
        end
        l = li;
        r = ri;
        t = ((l >> 4) ^ r) & 32'h0F0F0F0F;  r ^= t; l ^= t << 4;
        t = ((l >> 16) ^ r) & 32'h0000FFFF; r ^= t; l ^= t << 16;
        t = ((r >> 2) ^ l) & 32'h33333333;  l ^= t; r ^= t << 2;
        t = ((r >> 8) ^ l) & 32'h00FF00FF;  l ^= t; r ^= t << 8;
        r = {r[30:0], r[31]};
        t = (l ^ r) & 32'hAAAAAAAA; r ^= t; l ^= t;
        l = {l[30:0], l[31]};
        for (int p = 0; p < 3; p++) begin
            for (int n = 0; n < 16; n++) begin
                o = odd[p][n] ^ {r[3:0], r[31:4]};
                e = evn[p][n] ^ r;
                f = sp_lookup(0, o[29:24]) ^ sp_lookup(1, e[29:24]) ^ sp_lookup(2, o[21:16])
                  ^ sp_lookup(3, e[21:16]) ^ sp_lookup(4, o[13:8]) ^ sp_lookup(5, e[13:8])
                  ^ sp_lookup(6, o[5:0]) ^ sp_lookup(7, e[5:0]);
                t = l ^ f; l = r; r = t;
            end
            t = l; l = r; r = t;
        end
        l = {l[0], l[31:1]};
        t = (l ^ r) & 32'hAAAAAAAA; r ^= t; l ^= t;
        r = {r[0], r[31:1]};
        t = ((r >> 8) ^ l) & 32'h00FF00FF;  l ^= t; r ^= t << 8;
        t = ((r >> 2) ^ l) & 32'h33333333;  l ^= t; r ^= t << 2;
        t = ((l >> 16) ^ r) & 32'h0000FFFF; r ^= t; l ^= t << 16;
        t = ((l >> 4) ^ r) & 32'h0F0F0F0F;  r ^= t; l ^= t << 4;
        m_lo = r;
        m_hi = l;
    endtask

    task automatic predict_access(input logic act, input logic [25:0] off,
                                  input logic [31:0] wd);
        t_rsp x;
        x = '0;
        if (act == ACT_READ) begin
            if (off == REG_BASE + OFF_DATA_LO) x.rdata = m_lo;
            else if (off == REG_BASE + OFF_DATA_HI) x.rdata = m_hi;
            else x.bad = 1'b1;
        end else if (off == REG_BASE + OFF_DATA_LO) begin
            m_lo = wd;
        end else if (off == REG_BASE + OFF_DATA_HI) begin
            ede_encrypt(wd, m_lo);
            o_ciphers++;
        end else if (off >= REG_BASE + OFF_KEY_LO && off <= REG_BASE + OFF_KEY_HI
                     && off[1:0] == 2'b00) begin
            m_key[3'((off - REG_BASE - OFF_KEY_LO) >> 2)] = wd;
        end else begin
            x.bad = 1'b1;
        end
        rsp_q.push_back(x);
    endtask

    always @(posedge i_clk) begin
        t_rsp x;
        if (!i_rst_n) begin
            m_lo = '0;
            m_hi = '0;
            for (int i = 0; i < 6; i++) m_key[i] = '0;
            rsp_q.delete();
            o_errors  = 0;
            o_ciphers = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_q.size() == 0) begin
                    $display("%0t: unexpected response data=%h bad=%b", $time,
                             i_rsp_data, i_rsp_user);
                    o_errors++;
                end else begin
                    x = rsp_q.pop_front();
                    if (x.rdata !== i_rsp_data || x.bad !== i_rsp_user) begin
                        $display("%0t: mismatch expected data=%h bad=%b actual data=%h bad=%b",
                                 $time, x.rdata, x.bad, i_rsp_data, i_rsp_user);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                predict_access(i_req_user, i_req_data[25:0], i_req_data[57:26]);
        end
        o_pending = rsp_q.size();
    end
endmodule

FILE: tb/tb_triple_des_register_engine_core.sv
// ----------------------------------------------------------------------------
// Triple-DES register engine testbench
// Drives directed and random bus accesses with random stalls on both streams
// and reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb_triple_des_register_engine_core;
    import tdes_pkg::*;

    localparam logic [25:0] BASE      = 26'h10000;
    localparam logic        ACT_READ  = 1'b0;
    localparam logic        ACT_WRITE = 1'b1;
    localparam int          LIMIT     = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        m_user;
    int          errors, pending, ciphers;
    int          src_idle = 0, snk_idle = 0;
    int          n_sent = 0;
    int          cycles = 0;

    always #5 clk = ~clk;

    triple_des_register_engine_core #(.REG_BASE(BASE)) i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user)
    );

    tb_triple_des_register_engine_checker #(.REG_BASE(BASE)) i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_req_valid(s_valid), .i_req_ready(s_ready), .i_req_data(s_data),
        .i_req_user(s_user),
        .i_rsp_valid(m_valid), .i_rsp_ready(m_ready), .i_rsp_data(m_data),
        .i_rsp_user(m_user),
        .o_errors(errors), .o_pending(pending), .o_ciphers(ciphers)
    );

    always @(negedge clk) m_ready <= ($urandom_range(99) >= snk_idle);

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("** triple_des_register_engine_core: FAILED **");
            $finish;
        end
    end

    task automatic send_access(input logic act, input logic [25:0] off,
                               input logic [31:0] wd);
        @(negedge clk);
        while ($urandom_range(99) < src_idle) @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= {6'd0, wd, off};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
        s_valid <= 1'b0;
        n_sent++;
    endtask

    task automatic send_random;
        int k;
        logic [25:0] off;
        k = $urandom_range(99);
        if (k < 8) off = 26'($urandom);
        else if (k < 14) off = 26'(BASE + $urandom_range(31));
        else off = 26'(BASE + 4 * $urandom_range(7));
        send_access($urandom_range(99) < 60 ? ACT_WRITE : ACT_READ, off, $urandom);
    endtask

    task automatic drain;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_access(ACT_WRITE, BASE + OFF_DATA_HI, 32'h0);
        send_access(ACT_READ, BASE + OFF_DATA_LO, 32'h0);
        send_access(ACT_READ, BASE + OFF_DATA_HI, 32'hFFFFFFFF);
        for (int i = 0; i < 6; i++)
            send_access(ACT_WRITE, 26'(BASE + OFF_KEY_LO + 4 * i), 32'hFFFFFFFF);
        send_access(ACT_WRITE, BASE + OFF_DATA_LO, 32'hFFFFFFFF);
        send_access(ACT_WRITE, BASE + OFF_DATA_HI, 32'hFFFFFFFF);
        send_access(ACT_READ, BASE + OFF_DATA_LO, 32'h0);
        send_access(ACT_WRITE, 26'(BASE + OFF_KEY_LO + 4), 32'h0);
        send_access(ACT_WRITE, BASE + OFF_DATA_HI, 32'h01234567);
        send_access(ACT_READ, BASE + OFF_DATA_HI, 32'h0);
        send_access(ACT_READ, BASE + OFF_KEY_LO, 32'h0);
        send_access(ACT_WRITE, BASE + 26'h2, 32'h0);
        send_access(ACT_WRITE, BASE + 26'h20, 32'h5);
        send_access(ACT_READ, 26'h3FFFFFF, 32'h0);
        send_access(ACT_WRITE, 26'h0, 32'hA5A5A5A5);
        send_access(ACT_READ, 26'(BASE - 4), 32'h0);
        send_access(ACT_READ, BASE + OFF_DATA_LO, 32'h0);
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 36 : (ph == 1) ? 47 : 0;
            snk_idle = (ph == 0) ? 47 : (ph == 1) ? 36 : 0;
            for (int i = 0; i < 580; i++) begin
                send_random();
                if (i == 290 && ph == 1) drain();
            end
        end
        drain();
        repeat (80) @(posedge clk);
        $display("Ran %0d bus accesses including %0d cipher operations,", n_sent, ciphers);
        $display("with stalls on both streams and a full drain mid-run.");
        if (errors == 0 && pending == 0)
            $display("** triple_des_register_engine_core: PASSED **");
        else
            $display("** triple_des_register_engine_core: FAILED **");
        $finish;
    end
endmodule
